/* design/fmae_pkg.sv */
package fmae_pkg;

  localparam int COUNT_BITS = 24;
  localparam int SUM_BITS   = COUNT_BITS + 8;
  localparam int PIX_W      = 8;
  localparam int MEAN_W     = 8;
  localparam int EXP_W      = 16;
  localparam int GAIN_W     = 8;
  localparam int MAG_W      = 6;
  localparam int PROD_W     = MAG_W + 8;
  localparam int DIV_CNT_W  = $clog2(MEAN_W);

  // Queue depth must be a power of two so the pointers wrap on their own.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_HI   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_SCALE = 3'd6;

  localparam logic [7:0]       TARGET_RESET    = 8'd110;
  localparam logic [7:0]       TOLERANCE_RESET = 8'd8;
  localparam logic [EXP_W-1:0] EXP_MIN_RESET   = 16'd4;
  localparam logic [EXP_W-1:0] EXP_MAX_RESET   = 16'd3652;
  localparam logic [7:0]       GAIN_LO_RESET   = 8'd16;
  localparam logic [7:0]       GAIN_HI_RESET   = 8'd248;
  localparam logic [7:0]       SCALE_RESET     = 8'd20;
  localparam logic [EXP_W-1:0] EXP_NOW_RESET   = 16'd800;
  localparam logic [GAIN_W-1:0] GAIN_NOW_RESET = 8'd16;

  typedef struct packed {
    logic [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0] count;
    logic                  overflow;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic [7:0]        target;
    logic [7:0]        tolerance;
    logic [EXP_W-1:0]  exp_min;
    logic [EXP_W-1:0]  exp_max;
    logic [GAIN_W-1:0] gain_lo;
    logic [GAIN_W-1:0] gain_hi;
    logic [7:0]        exp_scale;
  } cfg_t;

  typedef struct packed {
    logic              frame_too_long;
    logic              gain_written;
    logic              exposure_written;
    logic [GAIN_W-1:0] gain;
    logic [EXP_W-1:0]  exposure;
    logic [MEAN_W-1:0] mean;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_STEP = 4'b0100,
    ST_ADJ  = 4'b1000
  } back_state_e;

endpackage

/* design/fmae_front.sv */
module fmae_front
  import fmae_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             last_i,
  input  logic             full_i,
  output logic             ready_o,
  output logic             push_o,
  output frame_t           frame_o
);

  logic [SUM_BITS-1:0]   sum_q, sum_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  ovf_q, ovf_d;
  logic                  accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    // A saturated counter stops both the sum and the count.
    if (count_q != '1) begin
      sum_d   = sum_q + {{(SUM_BITS-PIX_W){1'b0}}, pixel_i};
      count_d = count_q + 1'b1;
    end else begin
      ovf_d = 1'b1;
    end
  end

  assign push_o           = accept && last_i;
  assign frame_o.sum      = sum_d;
  assign frame_o.count    = count_d;
  assign frame_o.overflow = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      if (last_i) begin
        sum_q   <= '0;
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        sum_q   <= sum_d;
        count_q <= count_d;
        ovf_q   <= ovf_d;
      end
    end
  end

endmodule

/* design/fmae_queue.sv */
module fmae_queue
  import fmae_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  frame_t        data_i,
  input  logic          pop_i,
  output frame_t        data_o,
  output queue_status_t status_o
);

  frame_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]     fill_q;

  assign status_o.full  = (fill_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign status_o.empty = (fill_q == '0);
  assign data_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

/* design/fmae_back.sv */
module fmae_back
  import fmae_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    empty_i,
  input  frame_t  frame_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  back_state_e state_q, state_d;

  logic [SUM_BITS-1:0]   rem_q, rem_d;
  logic [SUM_BITS-1:0]   dvs_q, dvs_d;
  logic [COUNT_BITS-1:0] count_q;
  logic                  ovf_q;
  logic [MEAN_W-1:0]     quo_q, quo_d;
  logic [DIV_CNT_W-1:0]  iter_q;
  logic [MEAN_W-1:0]     mean_q;

  logic                  change_q, neg_q;
  logic [MAG_W-1:0]      mag_q;
  logic [PROD_W-1:0]     prod_q;

  logic [EXP_W-1:0]      exp_now_q;
  logic [GAIN_W-1:0]     gain_now_q;

  logic                  out_valid_q;
  result_t               result_q;

  logic                  fits;
  logic [MEAN_W-1:0]     mean_d;
  logic signed [MEAN_W:0] diff;
  logic [MEAN_W-1:0]     abs_diff;
  logic [MAG_W-1:0]      mag_d;

  logic signed [EXP_W+1:0]  exp_ext, prod_ext, exp_new;
  logic [EXP_W-1:0]         exp_clamp;
  logic signed [GAIN_W+1:0] gain_ext, mag_ext, gain_new;
  logic [GAIN_W-1:0]        gain_clamp;
  logic                     exp_w, gain_w, slot_free;

  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // One restoring step of the mean; the quotient never exceeds eight bits.
  always_comb begin
    fits   = (rem_q >= dvs_q);
    rem_d  = fits ? (rem_q - dvs_q) : rem_q;
    dvs_d  = dvs_q >> 1;
    quo_d  = {quo_q[MEAN_W-2:0], fits};
    mean_d = (count_q == '0) ? '0 : quo_d;
  end

  always_comb begin
    diff     = $signed({1'b0, cfg_i.target}) - $signed({1'b0, mean_q});
    abs_diff = diff[MEAN_W] ? MEAN_W'(-diff) : diff[MEAN_W-1:0];
    mag_d    = abs_diff[MEAN_W-1:2];
    if (mag_d == '0) begin
      mag_d = MAG_W'(1);
    end
  end

  always_comb begin
    exp_ext  = $signed({2'b00, exp_now_q});
    prod_ext = $signed({{(EXP_W+2-PROD_W){1'b0}}, prod_q});
    exp_new  = neg_q ? (exp_ext - prod_ext) : (exp_ext + prod_ext);
    // With crossed limits, a value below the lower limit takes it and any other takes the upper limit.
    if (exp_new < $signed({2'b00, cfg_i.exp_min})) begin
      exp_clamp = cfg_i.exp_min;
    end else if (exp_new > $signed({2'b00, cfg_i.exp_max})) begin
      exp_clamp = cfg_i.exp_max;
    end else begin
      exp_clamp = exp_new[EXP_W-1:0];
    end

    gain_ext = $signed({2'b00, gain_now_q});
    mag_ext  = $signed({{(GAIN_W+2-MAG_W){1'b0}}, mag_q});
    gain_new = neg_q ? (gain_ext - mag_ext) : (gain_ext + mag_ext);
    if (gain_new < $signed({2'b00, cfg_i.gain_lo})) begin
      gain_clamp = cfg_i.gain_lo;
    end else if (gain_new > $signed({2'b00, cfg_i.gain_hi})) begin
      gain_clamp = cfg_i.gain_hi;
    end else begin
      gain_clamp = gain_new[GAIN_W-1:0];
    end

    exp_w  = change_q && (exp_clamp != exp_now_q);
    gain_w = change_q && !exp_w && (gain_clamp != gain_now_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (iter_q == '1) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        state_d = ST_ADJ;
      end
      ST_ADJ: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      exp_now_q   <= EXP_NOW_RESET;
      gain_now_q  <= GAIN_NOW_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        iter_q <= '0;
      end else if (state_q == ST_DIV) begin
        iter_q <= iter_q + 1'b1;
      end
      if ((state_q == ST_ADJ) && slot_free) begin
        out_valid_q <= 1'b1;
        if (exp_w) begin
          exp_now_q <= exp_clamp;
        end
        if (gain_w) begin
          gain_now_q <= gain_clamp;
        end
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        rem_q   <= frame_i.sum;
        dvs_q   <= {1'b0, frame_i.count, {(MEAN_W-1){1'b0}}};
        count_q <= frame_i.count;
        ovf_q   <= frame_i.overflow;
        quo_q   <= '0;
      end
      ST_DIV: begin
        rem_q  <= rem_d;
        dvs_q  <= dvs_d;
        quo_q  <= quo_d;
        mean_q <= mean_d;
      end
      ST_STEP: begin
        change_q <= ($signed({1'b0, abs_diff}) > $signed({1'b0, cfg_i.tolerance}));
        neg_q    <= diff[MEAN_W];
        mag_q    <= mag_d;
        prod_q   <= {{(PROD_W-MAG_W){1'b0}}, mag_d} * {{(PROD_W-8){1'b0}}, cfg_i.exp_scale};
      end
      ST_ADJ: begin
        if (slot_free) begin
          result_q.mean             <= mean_q;
          result_q.exposure         <= exp_w ? exp_clamp : exp_now_q;
          result_q.gain             <= gain_w ? gain_clamp : gain_now_q;
          result_q.exposure_written <= exp_w;
          result_q.gain_written     <= gain_w;
          result_q.frame_too_long   <= ovf_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/frame_mean_auto_exposure.sv */
// Channel        Dir  Handshake                      Payload
// s_axis         in   s_axis_tvalid / s_axis_tready  tdata: pixel; tlast: last_of_frame
// m_axis         out  m_axis_tvalid / m_axis_tready  tdata: one frame result
// cfg            in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// Pixels are taken one per cycle while the queue is not full; the accumulator adds each
// one in the cycle it arrives. The end-of-frame work runs behind it: a start state that
// takes the frame from the queue, the restoring divider (one quotient bit per cycle), a
// state for error, step and multiply, and one that clamps and loads the result register.
// Two finished frames can wait in the queue; pixels stall only while it is full.
// Reset is asynchronous and active low and loads the register defaults, exposure 800
// and gain 16; no clearing pass is needed.
module frame_mean_auto_exposure
  import fmae_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata fields from bit 0: pixel[7:0]
  input  logic [PIX_W-1:0]      s_axis_tdata,
  input  logic                  s_axis_tlast,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata fields from bit 0: mean_brightness[7:0], exposure[23:8], gain[31:24],
  // exposure_written[32], gain_written[33], frame_too_long[34], zero fill[39:35]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t          cfg_q;
  logic          push, pop;
  frame_t        push_frame, head_frame;
  queue_status_t q_status;
  result_t       result;

  // Configuration is always accepted; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target    <= TARGET_RESET;
      cfg_q.tolerance <= TOLERANCE_RESET;
      cfg_q.exp_min   <= EXP_MIN_RESET;
      cfg_q.exp_max   <= EXP_MAX_RESET;
      cfg_q.gain_lo   <= GAIN_LO_RESET;
      cfg_q.gain_hi   <= GAIN_HI_RESET;
      cfg_q.exp_scale <= SCALE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TARGET:    cfg_q.target    <= cfg_data_i[7:0];
        CFG_TOLERANCE: cfg_q.tolerance <= cfg_data_i[7:0];
        CFG_EXP_MIN:   cfg_q.exp_min   <= cfg_data_i;
        CFG_EXP_MAX:   cfg_q.exp_max   <= cfg_data_i;
        CFG_GAIN_LO:   cfg_q.gain_lo   <= cfg_data_i[7:0];
        CFG_GAIN_HI:   cfg_q.gain_hi   <= cfg_data_i[7:0];
        CFG_EXP_SCALE: cfg_q.exp_scale <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // The front end sums and counts pixels and hands each closed frame to the queue.
  fmae_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .pixel_i (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .full_i  (q_status.full),
    .ready_o (s_axis_tready),
    .push_o  (push),
    .frame_o (push_frame)
  );

  fmae_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_frame),
    .pop_i    (pop),
    .data_o   (head_frame),
    .status_o (q_status)
  );

  // The back end forms the mean and runs the exposure and gain control loop.
  fmae_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (q_status.empty),
    .frame_i     (head_frame),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, result};

  // A closed frame must never be pushed into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_status.full)
    else $error("frame pushed into a full queue");

  // The back end only takes a frame that is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_status.empty)
    else $error("frame popped from an empty queue");

  // Exposure and gain never change on the same frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(result.exposure_written && result.gain_written))
    else $error("exposure and gain both written for one frame");

  // A fresh result never rises right after a pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(pop, 1))
    else $error("result appeared right after a pop");

endmodule

/* tb/frame_mean_auto_exposure_test.sv */
`timescale 1ns / 1ps

module frame_mean_auto_exposure_test;
  import fmae_pkg::*;

  // Index that maps to no register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // Cycles to let pass after the last result before a register write or the end.
  // The back end works on one frame at a time and the queue holds two frames.
  localparam int SETTLE_CYCLES = 32;

  // Pixel items aimed for in total, directed part included.
  localparam int PIXEL_ITEMS = 1550;
  localparam int PHASES      = 8;

  // Predicts one result per finished frame and checks the results in order.
  class exposure_scoreboard;
    cfg_t                  cfg;
    logic [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0] count;
    logic                  overflow;
    logic [EXP_W-1:0]      exposure;
    logic [GAIN_W-1:0]     gain;
    result_t               frame_results_q[$];
    int                    frames_checked;
    int                    errors;

    function new();
      cfg.target     = TARGET_RESET;
      cfg.tolerance  = TOLERANCE_RESET;
      cfg.exp_min    = EXP_MIN_RESET;
      cfg.exp_max    = EXP_MAX_RESET;
      cfg.gain_lo    = GAIN_LO_RESET;
      cfg.gain_hi    = GAIN_HI_RESET;
      cfg.exp_scale  = SCALE_RESET;
      sum            = '0;
      count          = '0;
      overflow       = 1'b0;
      exposure       = EXP_NOW_RESET;
      gain           = GAIN_NOW_RESET;
      frames_checked = 0;
      errors         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_TARGET:    cfg.target    = value[7:0];
        CFG_TOLERANCE: cfg.tolerance = value[7:0];
        CFG_EXP_MIN:   cfg.exp_min   = value[EXP_W-1:0];
        CFG_EXP_MAX:   cfg.exp_max   = value[EXP_W-1:0];
        CFG_GAIN_LO:   cfg.gain_lo   = value[GAIN_W-1:0];
        CFG_GAIN_HI:   cfg.gain_hi   = value[GAIN_W-1:0];
        CFG_EXP_SCALE: cfg.exp_scale = value[7:0];
        default: ;
      endcase
    endfunction

    // With crossed limits, a value below the lower limit takes it and any other takes the upper limit.
    function int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px, logic last);
      result_t           r;
      longint unsigned   s;
      longint unsigned   c;
      logic [MEAN_W-1:0] mean;
      int                mean_i, tgt, tol, diff, step;
      int                cur_exp, cur_gain, scale, next_exp, next_gain;
      int                lo, hi;
      if (count != {COUNT_BITS{1'b1}}) begin
        sum   = sum + px;
        count = count + 1'b1;
      end else begin
        overflow = 1'b1;
      end
      if (!last) return;

      s = sum;
      c = count;
      mean = (c != 0) ? MEAN_W'(s / c) : '0;
      r = '0;
      mean_i = mean;
      tgt    = cfg.target;
      tol    = cfg.tolerance;
      diff   = tgt - mean_i;
      if (diff > tol || diff < -tol) begin
        step = diff / 4;
        if (step == 0) step = (diff > 0) ? 1 : -1;
        cur_exp = exposure;
        scale   = cfg.exp_scale;
        lo      = cfg.exp_min;
        hi      = cfg.exp_max;
        next_exp = clamp_int(cur_exp + step * scale, lo, hi);
        if (next_exp != cur_exp) begin
          exposure = next_exp[EXP_W-1:0];
          r.exposure_written = 1'b1;
        end else begin
          cur_gain  = gain;
          lo        = cfg.gain_lo;
          hi        = cfg.gain_hi;
          next_gain = clamp_int(cur_gain + step, lo, hi);
          if (next_gain != cur_gain) begin
            gain = next_gain[GAIN_W-1:0];
            r.gain_written = 1'b1;
          end
        end
      end
      r.mean           = mean;
      r.exposure       = exposure;
      r.gain           = gain;
      r.frame_too_long = overflow;
      frame_results_q.push_back(r);
      sum      = '0;
      count    = '0;
      overflow = 1'b0;
    endfunction

    function int pending();
      return frame_results_q.size();
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("MISMATCH frame %0d %s: got %0d, expected %0d",
               frames_checked, what, got, want);
      errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
      result_t got;
      result_t want;
      got = data[$bits(result_t)-1:0];
      if (frame_results_q.size() == 0) begin
        report_mismatch("result with no frame pending", got.mean, 0);
        return;
      end
      want = frame_results_q.pop_front();
      if (got.mean != want.mean)
        report_mismatch("mean_brightness", got.mean, want.mean);
      if (got.exposure != want.exposure)
        report_mismatch("exposure", got.exposure, want.exposure);
      if (got.gain != want.gain)
        report_mismatch("gain", got.gain, want.gain);
      if (got.exposure_written != want.exposure_written)
        report_mismatch("exposure_written", got.exposure_written, want.exposure_written);
      if (got.gain_written != want.gain_written)
        report_mismatch("gain_written", got.gain_written, want.gain_written);
      if (got.frame_too_long != want.frame_too_long)
        report_mismatch("frame_too_long", got.frame_too_long, want.frame_too_long);
      if (data[OUT_DATA_W-1:$bits(result_t)] != '0)
        report_mismatch("zero fill", data[OUT_DATA_W-1:$bits(result_t)], 0);
      frames_checked++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;

  // Every input of the block starts from a known value.
  logic                  s_valid   = 1'b0;
  logic [PIX_W-1:0]      s_data    = '0;
  logic                  s_last    = 1'b0;
  logic                  m_ready   = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_ready_o;

  exposure_scoreboard sb = new();

  // When set, both sides run without idle cycles.
  bit calm = 1'b0;
  int pixels_sent = 0;

  // The scene drifts slowly, so that runs of dark or bright frames push
  // exposure and gain into their limits.
  int scene_lo = 0;
  int scene_hi = 255;

  frame_mean_auto_exposure dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(4, 0);
  endfunction

  // Offers one pixel item after a random number of idle cycles. The caller
  // is at a rising edge; the task returns at the edge where the item is taken.
  // Valid is lowered only when a gap follows, so it never toggles within a step.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= px;
    s_last  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(px, last);
    pixels_sent++;
  endtask

  // One frame of len pixels, each drawn uniformly from [lo, hi].
  task automatic send_frame(input int len, input int lo, input int hi);
    for (int i = 0; i < len; i++)
      send_pixel(PIX_W'($urandom_range(hi, lo)), i == len - 1);
  endtask

  // Registers change only while the block has nothing in flight.
  task automatic wait_idle();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One cycle with valid low follows every write, so back-to-back writes
  // never raise and lower valid in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random upper byte on 8-bit registers; the block must ignore it.
  function automatic logic [CFG_DATA_W-1:0] byte_reg(input int value);
    logic [CFG_DATA_W-1:0] v;
    v      = CFG_DATA_W'($urandom);
    v[7:0] = value[7:0];
    return v;
  endfunction

  // Writes every register for the next phase. Kinds: 0 reset values, 1 low
  // extremes, 2 high extremes, 3 tolerance so wide that nothing changes,
  // 4 crossed limits, anything else fully random (zero scale included).
  task automatic configure(input int kind);
    int tgt, tol, emin, emax, gmin, gmax, scale;
    case (kind)
      0: begin
        tgt = TARGET_RESET;  tol = TOLERANCE_RESET;
        emin = EXP_MIN_RESET; emax = EXP_MAX_RESET;
        gmin = GAIN_LO_RESET; gmax = GAIN_HI_RESET; scale = SCALE_RESET;
      end
      1: begin
        tgt = 0; tol = 0; emin = 0; emax = $urandom_range(3000, 0);
        gmin = 0; gmax = 255; scale = 1;
      end
      2: begin
        tgt = 255; tol = 0; emin = $urandom_range(500, 0); emax = 65535;
        gmin = 0; gmax = 255; scale = 255;
      end
      3: begin
        tgt = $urandom_range(255, 0); tol = 255;
        emin = 0; emax = 65535; gmin = 0; gmax = 255; scale = $urandom_range(255, 1);
      end
      4: begin
        tgt = $urandom_range(255, 0); tol = $urandom_range(20, 0);
        emax = $urandom_range(30000, 0); emin = $urandom_range(65535, emax + 1);
        gmax = $urandom_range(200, 0);   gmin = $urandom_range(255, gmax + 1);
        scale = $urandom_range(255, 0);
      end
      default: begin
        tgt = $urandom_range(255, 0); tol = $urandom_range(30, 0);
        emin = $urandom_range(2000, 0); emax = $urandom_range(65535, emin);
        gmin = $urandom_range(100, 0);  gmax = $urandom_range(255, gmin);
        scale = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(255, 1);
      end
    endcase
    write_reg(CFG_TARGET, byte_reg(tgt));
    write_reg(CFG_TOLERANCE, byte_reg(tol));
    write_reg(CFG_EXP_MIN, CFG_DATA_W'(emin));
    write_reg(CFG_EXP_MAX, CFG_DATA_W'(emax));
    write_reg(CFG_GAIN_LO, byte_reg(gmin));
    write_reg(CFG_GAIN_HI, byte_reg(gmax));
    write_reg(CFG_EXP_SCALE, byte_reg(scale));
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  // One random frame: mostly short, sometimes long; pixels follow the scene
  // except for an occasional frame of pure noise.
  task automatic random_frame();
    int len, center, width, pick;
    if ($urandom_range(5, 0) == 0) begin
      pick = $urandom_range(5, 0);
      if (pick == 0)      center = 0;
      else if (pick == 1) center = 255;
      else                center = $urandom_range(255, 0);
      width    = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(40, 0);
      scene_lo = (center - width < 0) ? 0 : center - width;
      scene_hi = (center + width > 255) ? 255 : center + width;
    end
    pick = $urandom_range(19, 0);
    if (pick < 14)      len = $urandom_range(16, 1);
    else if (pick < 19) len = $urandom_range(64, 17);
    else                len = $urandom_range(300, 65);
    if ($urandom_range(9, 0) == 0) send_frame(len, 0, 255);
    else                           send_frame(len, scene_lo, scene_hi);
  endtask

  // Result side: a random stall before each item, checked at the edge
  // where it is taken.
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  initial begin
    int phase_goal;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset values: darkest and brightest
    // frames, a truncated mean, errors right at and just past the tolerance.
    send_frame(1, 0, 0);
    send_frame(1, 255, 255);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd254, 1'b1);
    send_frame(1, 110, 110);
    send_frame(1, 118, 118);
    send_frame(1, 119, 119);

    // Zero tolerance: an error of one gives a step of zero, forced to one.
    wait_idle();
    write_reg(CFG_TOLERANCE, byte_reg(0));
    send_frame(1, 109, 109);
    send_frame(1, 111, 111);

    // Zero scale: exposure is stuck, so gain moves and clamps at its minimum.
    wait_idle();
    write_reg(CFG_EXP_SCALE, byte_reg(0));
    send_frame(1, 0, 0);
    send_frame(1, 255, 255);

    // Crossed limits for exposure and gain: a value below the lower limit takes it, any other the upper.
    wait_idle();
    write_reg(CFG_EXP_MIN, 16'd1000);
    write_reg(CFG_EXP_MAX, 16'd500);
    write_reg(CFG_GAIN_LO, byte_reg(200));
    write_reg(CFG_GAIN_HI, byte_reg(100));
    send_frame(1, 0, 0);
    send_frame(1, 255, 255);

    // Widest range and largest scale, then a write to an unused index.
    wait_idle();
    write_reg(CFG_EXP_MIN, 16'd0);
    write_reg(CFG_EXP_MAX, 16'hFFFF);
    write_reg(CFG_EXP_SCALE, byte_reg(255));
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_frame(1, 0, 0);
    send_frame(8, 255, 255);

    // Random part in phases, each with its own register setting; some phases
    // run with no stalls on either side.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        1:       configure(1);
        2:       configure(2);
        4:       configure(4);
        5:       configure(3);
        7:       configure(0);
        default: configure(5);
      endcase
      calm = (phase % 3 == 2);
      phase_goal = (PIXEL_ITEMS * (phase + 1)) / PHASES;
      while (pixels_sent < phase_goal) random_frame();
    end
    calm = 1'b0;

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
